// File: sv/vgpt_pkg.sv
// Package for the voxel grid point thinner: shared constants, mode and
// register codes, and parameter defaults. No dependencies.
`default_nettype none
package vgpt_pkg;

  // parameter defaults
  localparam int TABLE_SETS_DEF      = 1024;
  localparam int TABLE_WAYS_DEF      = 4;
  localparam int INDEX_BITS_DEF      = 20;
  localparam int COORD_FRAC_BITS_DEF = 16;

  // epoch tag stored with each way; zero marks a cleared way
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  // configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Q16.16 one
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  typedef enum logic [2:0] {
    MODE_RATE       = 3'd0,
    MODE_POINTS     = 3'd1,
    MODE_ID_FILTER  = 3'd2,
    MODE_ID_PASS    = 3'd3,
    MODE_BLOCK_PASS = 3'd4
  } thin_mode_e;

  typedef enum logic [2:0] {
    REG_THIN_MODE  = 3'd0,
    REG_RATE_INC   = 3'd1,
    REG_PTS_LIMIT  = 3'd2,
    REG_INV_RES_X  = 3'd3,
    REG_INV_RES_Y  = 3'd4,
    REG_INV_RES_Z  = 3'd5
  } cfg_reg_e;

endpackage
`default_nettype wire

// File: sv/vgpt_in_if.sv
// Point item channel: valid/ready handshake with point payload.
// No dependencies.
`default_nettype none
interface vgpt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic        [31:0] block_number;
  logic        [31:0] point_id;

  modport source (output valid, coord_x, coord_y, coord_z, block_number, point_id,
                  input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, block_number, point_id,
                  output ready);
endinterface
`default_nettype wire

// File: sv/vgpt_out_if.sv
// Result item channel: valid/ready handshake with keep/full flags.
// No dependencies.
`default_nettype none
interface vgpt_out_if;
  logic valid;
  logic ready;
  logic keep_point;
  logic table_full;

  modport source (output valid, keep_point, table_full, input ready);
  modport sink   (input valid, keep_point, table_full, output ready);
endinterface
`default_nettype wire

// File: sv/voxel_grid_point_thinner.sv
// Voxel grid point thinner top level: config registers, index pipeline,
// set-associative voxel table memory. Depends on vgpt_pkg, vgpt_in_if, vgpt_out_if.
`default_nettype none
// One point item is accepted per clock unless the output stalls, a clearing
// pass runs or an epoch wrap waits; the rate is set by one read-modify-write
// of one table set per item, the set written last forwarded to the item behind.
// The voxel table holds one row of TABLE_WAYS ways per set in a single memory.
// Block changes invalidate the table by bumping an epoch tag; after reset, and
// after every 255 clearing block changes, a clearing pass over all table sets
// runs during which no item is accepted (register writes still go through).
// A register write must only happen while no item is in flight.
module voxel_grid_point_thinner #(
  parameter int TABLE_SETS      = vgpt_pkg::TABLE_SETS_DEF,
  parameter int TABLE_WAYS      = vgpt_pkg::TABLE_WAYS_DEF,
  parameter int INDEX_BITS      = vgpt_pkg::INDEX_BITS_DEF,
  parameter int COORD_FRAC_BITS = vgpt_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  vgpt_in_if.sink                          pt_i,
  vgpt_out_if.source                       res_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [vgpt_pkg::CFG_AW-1:0] paddr,
  input  wire logic [vgpt_pkg::CFG_DW-1:0] pwdata,
  output logic      [vgpt_pkg::CFG_DW-1:0] prdata,
  output logic                             pready
);

  localparam int SET_W  = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
  localparam int WAY_W  = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
  localparam int KEY_W  = 3 * INDEX_BITS;
  localparam int PROD_W = 65;
  localparam int SH     = COORD_FRAC_BITS + 16;
  localparam int EW     = vgpt_pkg::EPOCH_W;
  localparam logic signed [PROD_W-1:0] IDX_HI =
    PROD_W'((64'sd1 <<< (INDEX_BITS - 1)) - 64'sd1);
  localparam logic signed [PROD_W-1:0] IDX_LO = -IDX_HI - PROD_W'(1);
  localparam logic [63:0] SET_MASK = 64'(TABLE_SETS - 1);

  typedef struct packed {
    logic [EW-1:0]    epoch;
    logic [KEY_W-1:0] vkey;
    logic [31:0]      idkey;
    logic [31:0]      policy;
  } way_t;
  typedef way_t [TABLE_WAYS-1:0] row_t;

  // ---------------------------------------------------------------- config
  logic [2:0]  thin_mode_q;
  logic [31:0] rate_inc_q, inv_x_q, inv_y_q, inv_z_q;
  logic [15:0] pts_limit_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thin_mode_q <= 3'(vgpt_pkg::MODE_RATE);
      rate_inc_q  <= 32'd131072;
      pts_limit_q <= 16'd1;
      inv_x_q     <= vgpt_pkg::ONE_Q16;
      inv_y_q     <= vgpt_pkg::ONE_Q16;
      inv_z_q     <= vgpt_pkg::ONE_Q16;
    end else if (cfg_we) begin
      case (paddr[4:2])
        vgpt_pkg::REG_THIN_MODE: thin_mode_q <= pwdata[2:0];
        vgpt_pkg::REG_RATE_INC:  rate_inc_q  <= pwdata;
        vgpt_pkg::REG_PTS_LIMIT: pts_limit_q <= pwdata[15:0];
        vgpt_pkg::REG_INV_RES_X: inv_x_q     <= pwdata;
        vgpt_pkg::REG_INV_RES_Y: inv_y_q     <= pwdata;
        vgpt_pkg::REG_INV_RES_Z: inv_z_q     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      vgpt_pkg::REG_THIN_MODE: prdata = {29'd0, thin_mode_q};
      vgpt_pkg::REG_RATE_INC:  prdata = rate_inc_q;
      vgpt_pkg::REG_PTS_LIMIT: prdata = {16'd0, pts_limit_q};
      vgpt_pkg::REG_INV_RES_X: prdata = inv_x_q;
      vgpt_pkg::REG_INV_RES_Y: prdata = inv_y_q;
      vgpt_pkg::REG_INV_RES_Z: prdata = inv_z_q;
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- control
  logic          adv, accept, blk_clr, wrap_need, sweep_start;
  logic          sweep_q;
  logic [SET_W-1:0] sweep_set_q;
  logic [EW-1:0] epoch_q, epoch_nx;
  logic [31:0]   last_block_q;
  logic          s1_vld_q, s2_vld_q, out_vld_q;

  assign adv       = !out_vld_q || res_o.ready;
  assign blk_clr   = (pt_i.block_number != last_block_q) &&
                     (thin_mode_q != 3'(vgpt_pkg::MODE_BLOCK_PASS));
  assign wrap_need = blk_clr && (epoch_q == vgpt_pkg::EPOCH_MAX);
  assign pt_i.ready = adv && !sweep_q && !wrap_need;
  assign accept    = pt_i.valid && pt_i.ready;
  assign sweep_start = !sweep_q && pt_i.valid && wrap_need && !s1_vld_q && !s2_vld_q;
  assign epoch_nx  = blk_clr ? epoch_q + EW'(1) : epoch_q;

  // epoch, last block and clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q      <= 1'b1;
      sweep_set_q  <= '0;
      epoch_q      <= EW'(1);
      last_block_q <= '0;
    end else begin
      if (sweep_q) begin
        sweep_set_q <= sweep_set_q + SET_W'(1);
        if (sweep_set_q == SET_W'(TABLE_SETS - 1)) begin
          sweep_q <= 1'b0;
        end
      end else if (sweep_start) begin
        sweep_q     <= 1'b1;
        sweep_set_q <= '0;
        epoch_q     <= '0;
      end
      if (accept) begin
        last_block_q <= pt_i.block_number;
        epoch_q      <= epoch_nx;
      end
    end
  end

  // ---------------------------------------------------------------- stage 1: multiply
  logic signed [PROD_W-1:0] s1_px_q, s1_py_q, s1_pz_q;
  logic [2:0]    s1_mode_q;
  logic [EW-1:0] s1_epoch_q;
  logic [31:0]   s1_block_q, s1_id_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q    <= $signed(pt_i.coord_x) * $signed({1'b0, inv_x_q});
      s1_py_q    <= $signed(pt_i.coord_y) * $signed({1'b0, inv_y_q});
      s1_pz_q    <= $signed(pt_i.coord_z) * $signed({1'b0, inv_z_q});
      s1_mode_q  <= thin_mode_q;
      s1_epoch_q <= epoch_nx;
      s1_block_q <= pt_i.block_number;
      s1_id_q    <= pt_i.point_id;
    end
  end

  // ---------------------------------------------------------------- stage 1: key, hash, read
  function automatic logic [INDEX_BITS-1:0] vox_idx(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] f;
    f = p >>> SH;
    if (f > IDX_HI) begin
      f = IDX_HI;
    end else if (f < IDX_LO) begin
      f = IDX_LO;
    end
    return f[INDEX_BITS-1:0];
  endfunction

  logic [KEY_W-1:0] s1_key;
  logic [31:0]      s1_idkey;
  logic [63:0]      s1_hash;
  logic [SET_W-1:0] s1_set;

  always_comb begin
    s1_key   = {vox_idx(s1_pz_q), vox_idx(s1_py_q), vox_idx(s1_px_q)};
    s1_idkey = (s1_mode_q == 3'(vgpt_pkg::MODE_ID_PASS)) ? 32'd0 : s1_id_q;
    s1_hash  = 64'(s1_key) ^ (64'(s1_key) >> INDEX_BITS) ^
               (64'(s1_key) >> (2 * INDEX_BITS)) ^
               64'(s1_idkey) ^ 64'(s1_idkey >> 16);
    s1_set   = SET_W'(s1_hash & SET_MASK);
  end

  logic [KEY_W-1:0] s2_key_q;
  logic [31:0]      s2_idkey_q, s2_block_q, s2_id_q;
  logic [SET_W-1:0] s2_set_q;
  logic [2:0]       s2_mode_q;
  logic [EW-1:0]    s2_epoch_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_key_q   <= s1_key;
      s2_idkey_q <= s1_idkey;
      s2_set_q   <= s1_set;
      s2_mode_q  <= s1_mode_q;
      s2_epoch_q <= s1_epoch_q;
      s2_block_q <= s1_block_q;
      s2_id_q    <= s1_id_q;
    end
  end

  // ---------------------------------------------------------------- voxel table memory
  row_t             mem_q [TABLE_SETS];
  row_t             rd_row_q;
  logic             mem_we, s2_we;
  logic [SET_W-1:0] mem_wa;
  row_t             mem_wd, row_new;

  assign mem_we = sweep_q || s2_we;
  assign mem_wa = sweep_q ? sweep_set_q : s2_set_q;
  assign mem_wd = sweep_q ? row_t'('0) : row_new;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_row_q <= mem_q[s1_set];
    end
  end

  // last written row, forwarded to the item that read the same set at that edge
  logic             wb_vld_q;
  logic [SET_W-1:0] wb_set_q;
  row_t             wb_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_vld_q <= 1'b0;
    end else if (sweep_q) begin
      wb_vld_q <= 1'b0;
    end else if (adv) begin
      wb_vld_q <= s2_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wb_set_q <= s2_set_q;
      wb_row_q <= row_new;
    end
  end

  // ---------------------------------------------------------------- stage 2: lookup and policy
  row_t             row_cur;
  logic             hit_found, free_found, mode_ok, full, keep;
  logic [WAY_W-1:0] hit_way, free_way, use_way;
  logic [31:0]      word, fresh, word_new;
  logic [32:0]      cnt_sum;
  logic [31:0]      cnt_sat;
  logic             way_vld;

  always_comb begin
    row_cur    = (wb_vld_q && (wb_set_q == s2_set_q)) ? wb_row_q : rd_row_q;
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_way    = '0;
    free_way   = '0;
    way_vld    = 1'b0;
    for (int w = 0; w < TABLE_WAYS; w++) begin
      way_vld = (row_cur[w].epoch == s2_epoch_q);
      if (way_vld) begin
        if (!hit_found && (row_cur[w].vkey == s2_key_q) &&
            (row_cur[w].idkey == s2_idkey_q)) begin
          hit_found = 1'b1;
          hit_way   = WAY_W'(w);
        end
      end else if (!free_found) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
    end
    use_way = hit_found ? hit_way : free_way;
    full    = !hit_found && !free_found;

    // fresh policy word and update
    mode_ok  = 1'b1;
    fresh    = '0;
    keep     = 1'b0;
    word_new = '0;
    cnt_sum  = '0;
    cnt_sat  = '0;
    case (s2_mode_q)
      vgpt_pkg::MODE_RATE:       fresh = rate_inc_q >> 1;
      vgpt_pkg::MODE_POINTS:     fresh = {16'd0, pts_limit_q};
      vgpt_pkg::MODE_ID_FILTER:  fresh = 32'd1;
      vgpt_pkg::MODE_ID_PASS:    fresh = s2_id_q;
      vgpt_pkg::MODE_BLOCK_PASS: fresh = s2_block_q;
      default:                   mode_ok = 1'b0;
    endcase
    word = hit_found ? row_cur[use_way].policy : fresh;

    case (s2_mode_q)
      vgpt_pkg::MODE_RATE: begin
        cnt_sum = {1'b0, word} + {1'b0, vgpt_pkg::ONE_Q16};
        cnt_sat = cnt_sum[32] ? '1 : cnt_sum[31:0];
        if (rate_inc_q == '0) begin
          word_new = '0;
        end else if (cnt_sat < rate_inc_q) begin
          word_new = cnt_sat;
        end else begin
          word_new = cnt_sat - rate_inc_q;
          keep     = 1'b1;
        end
      end
      vgpt_pkg::MODE_POINTS: begin
        keep     = (word != '0);
        word_new = keep ? word - 32'd1 : word;
      end
      vgpt_pkg::MODE_ID_FILTER: begin
        keep     = word[0];
        word_new = '0;
      end
      vgpt_pkg::MODE_ID_PASS: begin
        keep     = (s2_id_q == word);
        word_new = word;
      end
      vgpt_pkg::MODE_BLOCK_PASS: begin
        keep     = (s2_block_q == word);
        word_new = word;
      end
      default: ;
    endcase

    row_new = row_cur;
    row_new[use_way] = '{epoch: s2_epoch_q, vkey: s2_key_q,
                         idkey: s2_idkey_q, policy: word_new};
  end

  assign s2_we = adv && s2_vld_q && mode_ok && !full;

  // ---------------------------------------------------------------- valids and result register
  logic keep_q, full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= accept;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      keep_q <= mode_ok && !full && keep;
      full_q <= mode_ok && full;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.keep_point = keep_q;
  assign res_o.table_full = full_q;

  // ---------------------------------------------------------------- assertions
  a_sweep_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_q |-> !pt_i.ready)
    else $error("item accepted during clearing pass");

  a_keep_or_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.keep_point && res_o.table_full))
    else $error("result both kept and table full");

  // an accepted item never carries the reserved cleared-way epoch
  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (epoch_nx != '0))
    else $error("reserved epoch in use");

  a_sweep_empty_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sweep_q) |-> !s2_vld_q)
    else $error("clearing pass started with an item in flight");

endmodule
`default_nettype wire
